FILE: src/first_fit_block_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// first-fit allocator assertion macros
// shared concurrent assertion forms for the allocator checker
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, disabled while in reset
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

FILE: src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned STATUS_W     = 2;

  // operation kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd3;

  // one row of the block table
  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] offset;
  } entry_t;

  // compare unit verdict for the entry under test
  typedef struct packed {
    logic hit;
    logic last;
  } match_t;

endpackage

FILE: src/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ffba_match.sv
// ----------------------------------------------------------------------------
// ffba_match
// shared compare unit: tests one table entry against the pending request
// ----------------------------------------------------------------------------
module ffba_match
  import ffba_pkg::*;
#(
  parameter int unsigned IdxW = 6,
  parameter int unsigned CntW = 7
) (
  input  logic              kind_i,
  input  entry_t            entry_i,
  input  logic [ADDR_W-1:0] size_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [IdxW-1:0]   idx_i,
  input  logic [CntW-1:0]   count_i,
  output match_t            match_o
);

  always_comb begin
    if (kind_i == KIND_ALLOC) begin
      match_o.hit = entry_i.free && (entry_i.size >= size_i);
    end else begin
      match_o.hit = (entry_i.offset == addr_i);
    end
    match_o.last = ((CntW'(idx_i) + CntW'(1)) == count_i);
  end

endmodule

FILE: src/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// first-fit heap allocator over an address-ordered block table
// ----------------------------------------------------------------------------
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------------------
//   request   | start_i, busy_o        | kind_i, request_size_i, block_address_i
//   result    | done_o (strobe)        | payload_address_o, status_o,
//             |                        | heap_shrank_o, top_offset_o
//   config    | heap_limit_we_i        | heap_limit_i
//
// zero-size allocate and null release answer in the cycle after the transaction,
// busy_o stays low.
// other requests walk the block table one entry per cycle through the single
// ram read port and the compare unit.
// a table hit finishes in the cycle after its read data returns; a miss passes
// through the miss state for the append or unknown-address decision.
// reset clears block count and heap top and sets the limit to all ones; the table needs no clear.
// results cannot be stalled, done_o is high for one cycle per transaction.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int unsigned MaxBlocks   = MAX_BLOCKS,
  parameter int unsigned HeaderBytes = HEADER_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                kind_i,
  input  logic [ADDR_W-1:0]   request_size_i,
  input  logic [ADDR_W-1:0]   block_address_i,
  output logic                done_o,
  output logic [ADDR_W-1:0]   payload_address_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                heap_shrank_o,
  output logic [ADDR_W-1:0]   top_offset_o,
  input  logic                heap_limit_we_i,
  input  logic [ADDR_W-1:0]   heap_limit_i
);

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam int unsigned TopW = ADDR_W + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                kind_q, kind_d;
  logic [ADDR_W-1:0]   size_q, size_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [TopW-1:0]     new_top_q, new_top_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [ADDR_W-1:0]   top_q, top_d;
  logic [ADDR_W-1:0]   limit_q;
  logic                done_q, done_d;
  logic [ADDR_W-1:0]   paddr_q, paddr_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                shrank_q, shrank_d;

  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;
  match_t              match;
  logic [ADDR_W-1:0]   hdr_off;
  logic                no_room;

  ffba_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffba_match #(
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_match (
    .kind_i  (kind_q),
    .entry_i (ram_rdata),
    .size_i  (size_q),
    .addr_i  (addr_q),
    .idx_i   (idx_q),
    .count_i (count_q),
    .match_o (match)
  );

  assign hdr_off = top_q + ADDR_W'(HeaderBytes);
  assign no_room = (count_q >= CntW'(MaxBlocks)) || (new_top_q > TopW'(limit_q));

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    size_d    = size_q;
    addr_d    = addr_q;
    new_top_d = new_top_q;
    idx_d     = idx_q;
    count_d   = count_q;
    top_d     = top_q;
    done_d    = 1'b0;
    paddr_d   = paddr_q;
    status_d  = status_q;
    shrank_d  = shrank_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_raddr = idx_q;
    ram_wdata = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d    = kind_i;
          size_d    = request_size_i;
          addr_d    = block_address_i;
          new_top_d = TopW'(top_q) + TopW'(HeaderBytes) + TopW'(request_size_i);
          idx_d     = '0;
          if (kind_i == KIND_ALLOC && request_size_i == '0) begin
            done_d   = 1'b1;
            paddr_d  = '0;
            status_d = STATUS_ZERO;
            shrank_d = 1'b0;
          end else if (kind_i == KIND_RELEASE && block_address_i == '0) begin
            done_d   = 1'b1;
            paddr_d  = '0;
            status_d = STATUS_OK;
            shrank_d = 1'b0;
          end else if (count_q == '0) begin
            state_d = S_MISS;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (match.hit) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = STATUS_OK;
          shrank_d = 1'b0;
          paddr_d  = '0;
          if (kind_q == KIND_ALLOC) begin
            ram_we         = 1'b1;
            ram_wdata.free = 1'b0;
            paddr_d        = ram_rdata.offset;
          end else if (match.last) begin
            // popping the last block lowers the top to its header
            count_d  = CntW'(idx_q);
            top_d    = ram_rdata.offset - ADDR_W'(HeaderBytes);
            shrank_d = 1'b1;
          end else begin
            ram_we         = 1'b1;
            ram_wdata.free = 1'b1;
          end
        end else if (match.last) begin
          state_d = S_MISS;
        end else begin
          idx_d     = idx_q + IdxW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + IdxW'(1);
        end
      end

      S_MISS: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        paddr_d  = '0;
        shrank_d = 1'b0;
        if (kind_q == KIND_RELEASE) begin
          status_d = STATUS_UNKNOWN;
        end else if (no_room) begin
          status_d = STATUS_NO_ROOM;
        end else begin
          // append a new block at the heap top
          ram_we           = 1'b1;
          ram_waddr        = count_q[IdxW-1:0];
          ram_wdata.free   = 1'b0;
          ram_wdata.size   = size_q;
          ram_wdata.offset = hdr_off;
          count_d          = count_q + CntW'(1);
          top_d            = new_top_q[ADDR_W-1:0];
          paddr_d          = hdr_off;
          status_d         = STATUS_OK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      top_q   <= '0;
      limit_q <= '1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      top_q   <= top_d;
      done_q  <= done_d;
      if (heap_limit_we_i) begin
        limit_q <= heap_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    size_q    <= size_d;
    addr_q    <= addr_d;
    new_top_q <= new_top_d;
    idx_q     <= idx_d;
    paddr_q   <= paddr_d;
    status_q  <= status_d;
    shrank_q  <= shrank_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign payload_address_o = paddr_q;
  assign status_o          = status_q;
  assign heap_shrank_o     = shrank_q;
  assign top_offset_o      = top_q;

endmodule

FILE: src/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// port-level assertions for the first-fit block allocator
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_core_macros.svh"

module ffba_checker
  import ffba_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input logic [ADDR_W-1:0]   payload_address_o,
  input logic [STATUS_W-1:0] status_o,
  input logic                heap_shrank_o
);

  // a transaction either answers at once or keeps the block busy
  `FFBA_ASSERT_NXT(a_start_progress, clk_i, rst_ni, start_i && !busy_o, done_o || busy_o)

  // a result only appears once the block is free again
  `FFBA_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)

  // failed requests grant no address
  `FFBA_ASSERT_IMP(a_fail_null, clk_i, rst_ni, done_o && (status_o != STATUS_OK),
                   payload_address_o == '0)

  // a shrink only comes from a successful release, which grants nothing
  `FFBA_ASSERT_IMP(a_shrink_ok, clk_i, rst_ni, done_o && heap_shrank_o,
                   (status_o == STATUS_OK) && (payload_address_o == '0))

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);
